// ===== rtl/fc20_pkg.sv =====
// ----------------------------------------------------------------------------
// fc20_pkg
// shared types, constants and symbol maps for the 20-bit feistel cipher
// ----------------------------------------------------------------------------
package fc20_pkg;

  localparam int SYM_W   = 5;
  localparam int HALF_W  = 2 * SYM_W;
  localparam int KEY_W   = 4 * SYM_W;
  localparam int CHAR_W  = 8;
  localparam int DATA_W  = 4 * CHAR_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  localparam logic OP_ENCRYPT = 1'b0;
  localparam logic OP_DECRYPT = 1'b1;

  localparam logic [PADDR_W-1:0] REG_KEY_SYMBOLS = 3'd0;

  typedef logic [SYM_W-1:0]  sym_t;
  typedef logic [HALF_W-1:0] half_t;
  typedef logic [CHAR_W-1:0] char_t;

  typedef struct packed {
    logic  valid;
    sym_t  idx;
  } sym_lookup_t;

  // ascii byte to alphabet index
  function automatic sym_lookup_t char_to_sym(input char_t ch);
    sym_lookup_t res;
    res.valid = 1'b1;
    res.idx   = '0;
    if (ch >= 8'h41 && ch <= 8'h5a) begin
      res.idx = sym_t'(ch - 8'h41);
    end else begin
      unique case (ch)
        8'h20:   res.idx = sym_t'(26);
        8'h2e:   res.idx = sym_t'(27);
        8'h2c:   res.idx = sym_t'(28);
        8'h22:   res.idx = sym_t'(29);
        8'h21:   res.idx = sym_t'(30);
        8'h3f:   res.idx = sym_t'(31);
        default: res.valid = 1'b0;
      endcase
    end
    return res;
  endfunction

  // alphabet index back to ascii byte
  function automatic char_t sym_to_char(input sym_t idx);
    char_t ch;
    if (idx < sym_t'(26)) begin
      ch = 8'h41 + char_t'(idx);
    end else begin
      unique case (idx)
        sym_t'(26): ch = 8'h20;
        sym_t'(27): ch = 8'h2e;
        sym_t'(28): ch = 8'h2c;
        sym_t'(29): ch = 8'h22;
        sym_t'(30): ch = 8'h21;
        default:    ch = 8'h3f;
      endcase
    end
    return ch;
  endfunction

  // one feistel round: (l, r) -> (r, l ^ rotl1(r) ^ k), returned as {l, r}
  function automatic logic [2*HALF_W-1:0] feistel_round(input half_t l, input half_t r,
                                                        input half_t k);
    half_t rot;
    rot = {r[HALF_W-2:0], r[HALF_W-1]};
    return {r, l ^ rot ^ k};
  endfunction

endpackage

// ===== rtl/feistel_cipher_20bit.sv =====
// ----------------------------------------------------------------------------
// feistel_cipher_20bit
// four-round feistel cipher on four characters of a 32-symbol alphabet
// ----------------------------------------------------------------------------
// path: input register, then result register with the four rounds in between,
//   so every result transfer follows its input transfer through both registers
// throughput: one item per cycle while m_tready stays high; a stalled result
//   register backs up into the input register, then s_tready drops
// reset: rst clears the valid flags of both stages and the key register;
//   payload registers are not reset
module feistel_cipher_20bit (
  input  logic                        clk,
  input  logic                        rst,
  // input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  input  logic [fc20_pkg::DATA_W-1:0] s_tdata,   // in_char0, in_char1, in_char2, in_char3
  input  logic [0:0]                  s_tuser,   // op
  // result stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  output logic [fc20_pkg::DATA_W-1:0] m_tdata,   // out_char0, out_char1, out_char2, out_char3
  output logic [0:0]                  m_tuser,   // bad_symbol
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [fc20_pkg::PADDR_W-1:0] paddr,
  input  logic [fc20_pkg::PDATA_W-1:0] pwdata,
  output logic [fc20_pkg::PDATA_W-1:0] prdata,
  output logic                         pready
);

  // --------------------------------------------------------------------------
  // configuration: one key register at byte address 0
  // --------------------------------------------------------------------------
  logic [fc20_pkg::KEY_W-1:0] key_symbols;
  logic                       key_sel;

  assign pready  = 1'b1;
  // word decode, byte offset bits ignored
  assign key_sel = (paddr[fc20_pkg::PADDR_W-1:2] ==
                    fc20_pkg::REG_KEY_SYMBOLS[fc20_pkg::PADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      key_symbols <= '0;
    end else if (psel && penable && pwrite && pready && key_sel) begin
      key_symbols <= pwdata[fc20_pkg::KEY_W-1:0];
    end
  end

  assign prdata = key_sel ? {{(fc20_pkg::PDATA_W-fc20_pkg::KEY_W){1'b0}}, key_symbols} : '0;

  // --------------------------------------------------------------------------
  // handshake: two-stage pipeline, each stage advances when the next is free
  // --------------------------------------------------------------------------
  logic                        in_valid;
  logic [fc20_pkg::DATA_W-1:0] in_data;
  logic                        in_op;
  logic                        in_ready;
  logic                        out_ready;

  assign out_ready = !m_tvalid || m_tready;
  assign in_ready  = !in_valid || out_ready;
  assign s_tready  = in_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in_ready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && s_tvalid) begin
      in_data <= s_tdata;
      in_op   <= s_tuser[0];
    end
  end

  // --------------------------------------------------------------------------
  // cipher network between the two registers
  // --------------------------------------------------------------------------
  fc20_pkg::sym_lookup_t       look0, look1, look2, look3;
  logic                        bad;
  fc20_pkg::half_t             h0, h1;
  fc20_pkg::half_t             s0, s3;
  fc20_pkg::half_t             sub0, sub1, sub2, sub3;
  fc20_pkg::half_t             k0, k1, k2, k3;
  fc20_pkg::half_t             l0, r0;
  logic [2*fc20_pkg::HALF_W-1:0] st1, st2, st3, st4;
  fc20_pkg::half_t             res_l, res_r;
  logic [fc20_pkg::DATA_W-1:0] result_next;

  always_comb begin
    look0 = fc20_pkg::char_to_sym(in_data[7:0]);
    look1 = fc20_pkg::char_to_sym(in_data[15:8]);
    look2 = fc20_pkg::char_to_sym(in_data[23:16]);
    look3 = fc20_pkg::char_to_sym(in_data[31:24]);
    bad   = !(look0.valid && look1.valid && look2.valid && look3.valid);

    // halves: first character of each pair in the high bits
    h0 = {look0.idx, look1.idx};
    h1 = {look2.idx, look3.idx};

    // subkeys from adjacent key symbol pairs, last pair wraps around
    s0   = fc20_pkg::half_t'(key_symbols[19:15]);
    s3   = fc20_pkg::half_t'(key_symbols[4:0]);
    sub0 = key_symbols[19:10];
    sub1 = key_symbols[14:5];
    sub2 = key_symbols[9:0];
    sub3 = (s3 << fc20_pkg::SYM_W) | s0;

    // decrypt runs the schedule backwards on swapped halves
    if (in_op == fc20_pkg::OP_DECRYPT) begin
      l0 = h1; r0 = h0;
      k0 = sub3; k1 = sub2; k2 = sub1; k3 = sub0;
    end else begin
      l0 = h0; r0 = h1;
      k0 = sub0; k1 = sub1; k2 = sub2; k3 = sub3;
    end

    st1 = fc20_pkg::feistel_round(l0, r0, k0);
    st2 = fc20_pkg::feistel_round(st1[19:10], st1[9:0], k1);
    st3 = fc20_pkg::feistel_round(st2[19:10], st2[9:0], k2);
    st4 = fc20_pkg::feistel_round(st3[19:10], st3[9:0], k3);

    // decrypt undoes the swap on output
    if (in_op == fc20_pkg::OP_DECRYPT) begin
      res_l = st4[9:0];
      res_r = st4[19:10];
    end else begin
      res_l = st4[19:10];
      res_r = st4[9:0];
    end

    if (bad) begin
      result_next = '0;
    end else begin
      result_next = {fc20_pkg::sym_to_char(res_r[4:0]),
                     fc20_pkg::sym_to_char(res_r[9:5]),
                     fc20_pkg::sym_to_char(res_l[4:0]),
                     fc20_pkg::sym_to_char(res_l[9:5])};
    end
  end

  // --------------------------------------------------------------------------
  // result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_ready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && in_valid) begin
      m_tdata    <= result_next;
      m_tuser[0] <= bad;
    end
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the four-round feistel cipher: fixed and random keys over apb,
// bursty input stream, stalling result stream, results checked in order
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

  // two register stages between input and result transfer
  localparam int PIPE_LATENCY   = 2;
  // cycles without any transfer before the run is declared hung
  localparam int WATCHDOG_LIMIT = 4000;
  // items per random key phase
  localparam int PHASE_ITEMS    = 220;
  // the 32 glyphs in index order, index 0 in the top byte
  localparam logic [8*32-1:0] GLYPHS = "ABCDEFGHIJKLMNOPQRSTUVWXYZ .,\"!?";

  // expected result: chars[0] is the first character, as on tdata
  typedef struct packed {
    logic                             bad;
    logic [3:0][fc20_pkg::CHAR_W-1:0] chars;
  } cipher_block_t;

  logic                          clk      = 1'b0;
  logic                          rst      = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [fc20_pkg::DATA_W-1:0]   s_tdata  = '0;   // in_char0, in_char1, in_char2, in_char3
  logic [0:0]                    s_tuser  = '0;   // op
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [fc20_pkg::DATA_W-1:0]   m_tdata;         // out_char0, out_char1, out_char2, out_char3
  logic [0:0]                    m_tuser;         // bad_symbol
  logic                          psel     = 1'b0;
  logic                          penable  = 1'b0;
  logic                          pwrite   = 1'b0;
  logic [fc20_pkg::PADDR_W-1:0]  paddr    = '0;
  logic [fc20_pkg::PDATA_W-1:0]  pwdata   = '0;
  logic [fc20_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // predictor state: the key as the block should hold it
  logic [fc20_pkg::KEY_W-1:0]    cipher_key = '0;
  cipher_block_t                 pending_blocks[$];
  int                            error_count = 0;

  // sender burst bookkeeping
  int                  burst_left = 0;

  // receiver stall pattern and long hold request
  int                  rx_left        = 0;
  logic                rx_ready_phase = 1'b0;
  int                  rx_hold_left   = 0;
  int                  rx_hold_req    = 0;

  int                  idle_cycles    = 0;

  feistel_cipher_20bit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // glyph for an alphabet index
  function automatic logic [fc20_pkg::CHAR_W-1:0] glyph_char(
      input logic [fc20_pkg::SYM_W-1:0] idx);
    return GLYPHS[8*(31-idx) +: 8];
  endfunction

  // expected cipher output for one block under the given key
  function automatic cipher_block_t feistel_result(
      input logic                             op,
      input logic [3:0][fc20_pkg::CHAR_W-1:0] chars,
      input logic [fc20_pkg::KEY_W-1:0]       key);
    cipher_block_t                     res;
    logic [3:0][fc20_pkg::SYM_W-1:0]   idx;
    logic [3:0][fc20_pkg::HALF_W-1:0]  subkey;
    logic [fc20_pkg::HALF_W-1:0]       lh, rh, tmp;
    logic                              found;
    res = '0;
    for (int k = 0; k < 4; k++) begin
      found  = 1'b0;
      idx[k] = '0;
      for (int g = 0; g < 32; g++) begin
        if (!found && glyph_char(g[fc20_pkg::SYM_W-1:0]) == chars[k]) begin
          found  = 1'b1;
          idx[k] = g[fc20_pkg::SYM_W-1:0];
        end
      end
      if (!found) res.bad = 1'b1;
    end
    // any character outside the alphabet: flag set, characters zero
    if (res.bad) return res;

    // subkeys from neighboring key symbol pairs, last one wraps around
    subkey[0] = key[19:10];
    subkey[1] = key[14:5];
    subkey[2] = key[9:0];
    subkey[3] = {key[4:0], key[19:15]};

    if (op == fc20_pkg::OP_ENCRYPT) begin
      lh = {idx[0], idx[1]};
      rh = {idx[2], idx[3]};
      for (int k = 0; k < 4; k++) begin
        tmp = lh ^ {rh[fc20_pkg::HALF_W-2:0], rh[fc20_pkg::HALF_W-1]} ^ subkey[k];
        lh  = rh;
        rh  = tmp;
      end
    end else begin
      // halves swapped in, subkeys reversed, halves swapped out
      lh = {idx[2], idx[3]};
      rh = {idx[0], idx[1]};
      for (int k = 3; k >= 0; k--) begin
        tmp = lh ^ {rh[fc20_pkg::HALF_W-2:0], rh[fc20_pkg::HALF_W-1]} ^ subkey[k];
        lh  = rh;
        rh  = tmp;
      end
      tmp = lh;
      lh  = rh;
      rh  = tmp;
    end
    res.chars[0] = glyph_char(lh[9:5]);
    res.chars[1] = glyph_char(lh[4:0]);
    res.chars[2] = glyph_char(rh[9:5]);
    res.chars[3] = glyph_char(rh[4:0]);
    return res;
  endfunction

  // one input transfer; a new burst may start with a random gap first
  task automatic send_block(input logic op,
                            input logic [3:0][fc20_pkg::CHAR_W-1:0] chars);
    int gap;
    if (burst_left == 0) begin
      // occasional long bursts give stretches with no idling
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 90)
                                               : $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= chars;
    s_tuser  <= op;
    do @(posedge clk); while (!s_tready);
    pending_blocks.push_back(feistel_result(op, chars, cipher_key));
  endtask

  // mostly in-alphabet text, some noise bytes and single corrupted characters
  task automatic send_random_block();
    logic [3:0][fc20_pkg::CHAR_W-1:0] chars;
    int                               kind;
    int unsigned                      rnd;
    kind = $urandom_range(0, 9);
    for (int k = 0; k < 4; k++) begin
      rnd      = $urandom;
      chars[k] = glyph_char(rnd[fc20_pkg::SYM_W-1:0]);
    end
    if (kind == 0) begin
      chars = $urandom;
    end else if (kind == 1) begin
      rnd             = $urandom;
      chars[rnd[9:8]] = rnd[7:0];
    end
    rnd = $urandom;
    send_block(rnd[0], chars);
  endtask

  // sender stops and waits until every expected result has come back
  task automatic wait_for_results();
    s_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY + 2) @(posedge clk);
  endtask

  // key write while idle, then a read back of the register
  task automatic program_key(input logic [fc20_pkg::PDATA_W-1:0] value);
    logic [fc20_pkg::PDATA_W-1:0] readback;
    wait_for_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= fc20_pkg::REG_KEY_SYMBOLS;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    cipher_key = value[fc20_pkg::KEY_W-1:0];
    // read setup follows the write access directly
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback[fc20_pkg::KEY_W-1:0] !== cipher_key) begin
      if (error_count < 10)
        $display("key readback mismatch: expected %h, got %h", cipher_key,
                 readback[fc20_pkg::KEY_W-1:0]);
      error_count++;
    end
  endtask

  // key still at reset value, extreme glyphs both ways
  task automatic test_reset_key();
    // the last letter of each literal lands in char0
    send_block(fc20_pkg::OP_ENCRYPT, "AAAA");
    send_block(fc20_pkg::OP_DECRYPT, "AAAA");
    send_block(fc20_pkg::OP_ENCRYPT, "????");
    send_block(fc20_pkg::OP_DECRYPT, " .,\"");
  endtask

  // all-ones key and a mixed pattern key
  task automatic test_extreme_keys();
    program_key(32'hffff_ffff);
    send_block(fc20_pkg::OP_ENCRYPT, "!?AZ");
    send_block(fc20_pkg::OP_DECRYPT, "ZZZZ");
    send_block(fc20_pkg::OP_ENCRYPT, "\"., ");
    send_block(fc20_pkg::OP_DECRYPT, "?!\"A");
    program_key(32'h000a_5a5a);
    send_block(fc20_pkg::OP_ENCRYPT, "HELP");
    send_block(fc20_pkg::OP_DECRYPT, "HELP");
  endtask

  // bytes just outside the alphabet, one bad character in each position
  task automatic test_bad_symbols();
    send_block(fc20_pkg::OP_ENCRYPT, {"AAA", 8'h40});
    send_block(fc20_pkg::OP_DECRYPT, {"AA", 8'h5b, "A"});
    send_block(fc20_pkg::OP_ENCRYPT, {"A", 8'h61, "AA"});
    send_block(fc20_pkg::OP_DECRYPT, {8'h23, "AAA"});
    send_block(fc20_pkg::OP_ENCRYPT, {8'h2d, 8'h2f, 8'h3e, 8'h1f});
    send_block(fc20_pkg::OP_ENCRYPT, {4{8'h00}});
    send_block(fc20_pkg::OP_DECRYPT, {4{8'hff}});
    send_block(fc20_pkg::OP_ENCRYPT, {"?", 8'h7f, " ", 8'h80});
  endtask

  // one key phase of random traffic
  task automatic test_random_traffic(input logic [fc20_pkg::PDATA_W-1:0] key,
                                     input int count);
    program_key(key);
    repeat (count) send_random_block();
  endtask

  // receiver holds off long enough that the block fills and stalls its input
  task automatic test_output_backpressure();
    rx_hold_req = 300;
    repeat (60) send_random_block();
    wait_for_results();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_reset_key();
    test_extreme_keys();
    test_bad_symbols();
    test_random_traffic(32'h0000_0000, PHASE_ITEMS);
    test_random_traffic(32'h000f_ffff, PHASE_ITEMS);
    test_output_backpressure();
    repeat (5) test_random_traffic($urandom, PHASE_ITEMS);
    wait_for_results();
    if (error_count == 0 && pending_blocks.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // receiver: alternating ready and stall runs, plus the long hold on request
  always @(posedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
    end else if (rx_left > 0) begin
      rx_left--;
    end else begin
      rx_ready_phase = !rx_ready_phase;
      if (rx_ready_phase) begin
        rx_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                              : $urandom_range(0, 10);
      end else begin
        rx_left = $urandom_range(0, 5);
      end
    end
    m_tready <= rx_ready_phase && (rx_hold_left == 0);
  end

  // result checker: each result transfer against the oldest expectation
  always @(posedge clk) begin
    cipher_block_t expected;
    logic          wrong;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_blocks.size() == 0) begin
        if (error_count < 10)
          $display("unexpected result: chars %h bad %b", m_tdata, m_tuser);
        error_count++;
      end else begin
        expected = pending_blocks.pop_front();
        wrong    = (m_tuser[0] !== expected.bad);
        for (int k = 0; k < 4; k++)
          if (m_tdata[8*k +: 8] !== expected.chars[k]) wrong = 1'b1;
        if (wrong) begin
          if (error_count < 10)
            $display("result mismatch: expected chars %h bad %b, got chars %h bad %b",
                     expected.chars, expected.bad, m_tdata, m_tuser[0]);
          error_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transfer anywhere
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

endmodule
